### hw/rtl/mfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants
// Command codes, screen defaults and helper functions for the framebuffer.
// ----------------------------------------------------------------------------
package mfb_pkg;

	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;

	localparam logic [2:0] CMD_CLEAR  = 3'd0;
	localparam logic [2:0] CMD_FILL   = 3'd1;
	localparam logic [2:0] CMD_INVERT = 3'd2;
	localparam logic [2:0] CMD_ARM    = 3'd3;
	localparam logic [2:0] CMD_PULL   = 3'd4;

	localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
	localparam logic [7:0] COL_HI_CMD    = 8'h10;
	localparam logic [7:0] NIBBLE_MASK   = 8'h0F;

	// Read-modify-write request from the sequencer to the store.
	typedef struct packed {
		logic       wr;
		logic [1:0] op;
		logic [7:0] mask;
	} rmw_t;

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7-i] = v[i];
		end
		return r;
	endfunction

	// Row mask of one page; top row in the MSB.
	function automatic logic [7:0] page_mask(input logic [2:0] top, input logic [2:0] bot);
		logic [7:0] a;
		logic [7:0] b;
		a = 8'hFF >> top;
		b = 8'hFF << (3'd7 - bot);
		return a & b;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mfb_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfb_store: frame memory with read-modify-write unit
// One-port byte memory; a read returns registered data, a write applies the
// clear/fill/invert mask to the byte read before. Clearing pass after reset.
// ----------------------------------------------------------------------------
module mfb_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [AW-1:0] addr,
	input  wire mfb_pkg::rmw_t rmw,
	output logic [7:0]         rdata,
	output logic               init_busy
);
	import mfb_pkg::*;

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          busy_q;
	logic [7:0]    new_byte;

	// modified byte from the last read
	always_comb begin
		case (rmw.op)
			2'd0:    new_byte = rdata & ~rmw.mask;
			2'd1:    new_byte = rdata | rmw.mask;
			default: new_byte = rdata ^ rmw.mask;
		endcase
	end

	// clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == AW'(DEPTH - 1)) busy_q <= 1'b0;
		end
	end
	assign init_busy = busy_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= 8'h00;
		end else if (rmw.wr) begin
			mem[addr] <= new_byte;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

### hw/rtl/mono_framebuffer_dirty_refresh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_dirty_refresh: page framebuffer with dirty-rect refresh
// Draws clear/fill/invert rectangles and streams dirty pages to a panel.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one command beat. Drawing beats
// run a sequencer over the clipped rectangle: each byte passes a read state
// and a modify-write state through the single memory port, and with
// refresh_after the arm state follows the last byte. A rectangle fully off
// screen skips the sequencer. The input is stalled while drawing and in the
// arm state. A pull passes a read state and a wait state and then presents
// its output beat on out_valid/out_stall (a pull with no refresh under way:
// the next cycle). The result waits in an output register while the
// receiver stalls; the next input beat is taken in the cycle after it
// leaves, so a new pull is not taken before the previous result has left.
// After reset the frame memory (SCREEN_WIDTH times pages bytes, 1024 by
// default) is cleared, one byte a cycle; in_stall is high meanwhile.
// The dirty region starts empty and no refresh is pending.
// Unused command codes are consumed with no output beat.
// ----------------------------------------------------------------------------
module mono_framebuffer_dirty_refresh #(
	parameter int SCREEN_WIDTH  = mfb_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = mfb_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] corner_a_x,
	input  wire logic [7:0] corner_a_y,
	input  wire logic [7:0] corner_b_x,
	input  wire logic [7:0] corner_b_y,
	input  wire logic       refresh_after,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      panel_byte,
	output logic            is_command,
	output logic            last_of_refresh,
	output logic            nothing_pending
);
	import mfb_pkg::*;

	localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
	localparam int DEPTH = SCREEN_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam logic [7:0] XMAX = 8'(SCREEN_WIDTH - 1);
	localparam logic [7:0] YMAX = 8'(SCREEN_HEIGHT - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_WR    = 3'd2;
	localparam logic [2:0] ST_ARM   = 3'd3;
	localparam logic [2:0] ST_PREAD = 3'd4;
	localparam logic [2:0] ST_PWAIT = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [7:0] xl_q, xh_q, yl_q, yh_q, col_q;
	logic [PW-1:0] pg_q;
	logic [1:0] op_q;
	logic rf_q;
	logic [7:0] dxl_q, dxh_q, dyl_q, dyh_q;
	logic dany_q;
	logic [7:0] wcl_q, wch_q;
	logic [PW-1:0] wpl_q, wph_q, cpg_q;
	logic [8:0] cpos_q;
	logic sact_q;
	logic [7:0] ob_q;
	logic oc_q, ol_q, on_q;
	logic [7:0] rdata;
	logic init_busy;
	rmw_t rmw;
	logic [AW-1:0] addr;
	logic accept;
	logic [7:0] ixl, ixh, iyl, iyh;
	logic [7:0] mask;
	logic [7:0] pg_r0;
	logic [2:0] top, bot;
	logic [8:0] ncols;

	assign accept   = in_valid && !in_stall;
	assign in_stall = init_busy || (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign panel_byte = ob_q;
	assign is_command = oc_q;
	assign last_of_refresh = ol_q;
	assign nothing_pending = on_q;

	// corner normalizing
	assign ixl = (corner_a_x < corner_b_x) ? corner_a_x : corner_b_x;
	assign ixh = (corner_a_x < corner_b_x) ? corner_b_x : corner_a_x;
	assign iyl = (corner_a_y < corner_b_y) ? corner_a_y : corner_b_y;
	assign iyh = (corner_a_y < corner_b_y) ? corner_b_y : corner_a_y;

	// mask of the current page
	assign pg_r0 = 8'({pg_q, 3'b000});
	assign top = (yl_q > pg_r0) ? 3'(yl_q - pg_r0) : 3'd0;
	assign bot = (yh_q < pg_r0 + 8'd7) ? 3'(yh_q - pg_r0) : 3'd7;
	assign mask = page_mask(top, bot);

	assign ncols = {1'b0, wch_q} - {1'b0, wcl_q} + 9'd1;

	// single memory address: drawing cursor or send cursor
	always_comb begin
		if (state_q == ST_RD || state_q == ST_WR)
			addr = AW'(col_q * PAGES + pg_q);
		else
			addr = AW'((wcl_q + 8'(cpos_q - 9'd3)) * PAGES + cpg_q);
	end

	assign rmw.wr   = (state_q == ST_WR);
	assign rmw.op   = op_q;
	assign rmw.mask = mask;

	mfb_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk(clk), .arst_n(arst_n), .addr(addr), .rmw(rmw),
		.rdata(rdata), .init_busy(init_busy)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dxl_q <= XMAX; dxh_q <= '0; dyl_q <= YMAX; dyh_q <= '0;
			dany_q <= 1'b0;
			wcl_q <= '0; wch_q <= '0; wpl_q <= '0; wph_q <= '0;
			cpg_q <= '0; cpos_q <= '0; sact_q <= 1'b0;
			rf_q <= 1'b0;
			op_q <= '0; col_q <= '0; pg_q <= '0;
			xl_q <= '0; xh_q <= '0; yl_q <= '0; yh_q <= '0;
			ob_q <= '0; oc_q <= 1'b0; ol_q <= 1'b0; on_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rf_q <= refresh_after;
						op_q <= cmd[1:0];
						if (cmd == CMD_CLEAR || cmd == CMD_FILL || cmd == CMD_INVERT) begin
							if (ixl > XMAX || iyl > YMAX) begin
								state_q <= refresh_after ? ST_ARM : ST_IDLE;
							end else begin
								xl_q <= ixl; yl_q <= iyl;
								xh_q <= (ixh > XMAX) ? XMAX : ixh;
								yh_q <= (iyh > YMAX) ? YMAX : iyh;
								col_q <= ixl;
								pg_q <= PW'(iyl >> 3);
								state_q <= ST_RD;
							end
						end else if (cmd == CMD_ARM) begin
							state_q <= ST_ARM;
						end else if (cmd == CMD_PULL) begin
							if (!sact_q) begin
								ob_q <= '0; oc_q <= 1'b0; ol_q <= 1'b0; on_q <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_PREAD;
							end
						end
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (col_q != xh_q) begin
						col_q <= col_q + 8'd1;
						state_q <= ST_RD;
					end else if (pg_q != PW'(yh_q >> 3)) begin
						col_q <= xl_q;
						pg_q <= pg_q + 1'b1;
						state_q <= ST_RD;
					end else begin
						if (!dany_q) begin
							dxl_q <= xl_q; dxh_q <= xh_q; dyl_q <= yl_q; dyh_q <= yh_q;
							dany_q <= 1'b1;
						end else begin
							if (xl_q < dxl_q) dxl_q <= xl_q;
							if (xh_q > dxh_q) dxh_q <= xh_q;
							if (yl_q < dyl_q) dyl_q <= yl_q;
							if (yh_q > dyh_q) dyh_q <= yh_q;
						end
						state_q <= rf_q ? ST_ARM : ST_IDLE;
					end
				end
				ST_ARM: begin
					if (!sact_q && dany_q) begin
						wcl_q <= dxl_q; wch_q <= dxh_q;
						wpl_q <= PW'(dyl_q >> 3); wph_q <= PW'(dyh_q >> 3);
						cpg_q <= PW'(dyl_q >> 3); cpos_q <= '0;
						sact_q <= 1'b1; dany_q <= 1'b0;
						dxl_q <= XMAX; dxh_q <= '0; dyl_q <= YMAX; dyh_q <= '0;
					end
					state_q <= ST_IDLE;
				end
				ST_PREAD: state_q <= ST_PWAIT;
				ST_PWAIT: begin
					on_q <= 1'b0;
					ol_q <= 1'b0;
					oc_q <= (cpos_q < 9'd3);
					if (cpos_q == 9'd0)
						ob_q <= PAGE_CMD_BASE + (8'(cpg_q) & NIBBLE_MASK);
					else if (cpos_q == 9'd1)
						ob_q <= COL_HI_CMD | ((wcl_q >> 4) & NIBBLE_MASK);
					else if (cpos_q == 9'd2)
						ob_q <= wcl_q & NIBBLE_MASK;
					else
						ob_q <= reverse8(rdata);
					if (cpos_q >= 9'd2 + ncols) begin
						cpos_q <= '0;
						if (cpg_q >= wph_q) begin
							ol_q <= 1'b1; sact_q <= 1'b0; cpg_q <= '0;
						end else begin
							cpg_q <= cpg_q + 1'b1;
						end
					end else begin
						cpos_q <= cpos_q + 9'd1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> in_stall) else $error("input taken during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(panel_byte))
		else $error("output dropped under stall");
	a_none_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && nothing_pending |-> !is_command && !last_of_refresh)
		else $error("bad idle pull result");
	a_win_order: assert property (@(posedge clk) disable iff (!arst_n)
		sact_q |-> wcl_q <= wch_q && wpl_q <= wph_q) else $error("bad window");

endmodule

`default_nettype wire

### verif/framebuffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_checker: panel stream scoreboard
// Watches the command and panel channels, keeps its own copy of the pixel
// store and dirty region, predicts every panel beat and compares by field.
// ----------------------------------------------------------------------------
module framebuffer_checker
	import mfb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] corner_a_x,
	input  logic [7:0] corner_a_y,
	input  logic [7:0] corner_b_x,
	input  logic [7:0] corner_b_y,
	input  logic       refresh_after,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] panel_byte,
	input  logic       is_command,
	input  logic       last_of_refresh,
	input  logic       nothing_pending,
	output int         fail_count,
	output int         beats_owed,
	output bit         streaming
);

	localparam int WIDTH = DEF_SCREEN_WIDTH;
	localparam int HEIGHT = DEF_SCREEN_HEIGHT;
	localparam int PAGES = (HEIGHT + 7) / 8;

	typedef struct {
		logic [7:0] pbyte;
		logic       cmd_flag;
		logic       last_flag;
		logic       idle_flag;
	} panel_beat_t;

	panel_beat_t panel_q[$];

	// shadow of the block state
	logic [7:0]  pixels [WIDTH*PAGES];
	int unsigned dirty_xl, dirty_xh, dirty_yl, dirty_yh;
	bit          dirty_set;
	int unsigned win_cl, win_ch, win_pl, win_ph;
	int unsigned cur_page, cur_pos;
	bit          sending;
	int          fails;

	function automatic logic [7:0] flip_byte(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[7-i] = v[i];
		return r;
	endfunction

	task automatic clear_shadow();
		foreach (pixels[i]) pixels[i] = 8'h00;
		dirty_xl = WIDTH - 1;
		dirty_xh = 0;
		dirty_yl = HEIGHT - 1;
		dirty_yh = 0;
		dirty_set = 0;
		win_cl = 0; win_ch = 0; win_pl = 0; win_ph = 0;
		cur_page = 0; cur_pos = 0;
		sending = 0;
	endtask

	// snapshot the dirty region into the send window
	task automatic start_refresh();
		if (sending || !dirty_set) return;
		win_cl = dirty_xl;
		win_ch = dirty_xh;
		win_pl = dirty_yl / 8;
		win_ph = dirty_yh / 8;
		cur_page = win_pl;
		cur_pos = 0;
		sending = 1;
		dirty_set = 0;
		dirty_xl = WIDTH - 1;
		dirty_xh = 0;
		dirty_yl = HEIGHT - 1;
		dirty_yh = 0;
	endtask

	task automatic paint_rect(input logic [2:0] op, input int unsigned ax, input int unsigned ay,
				  input int unsigned bx, input int unsigned by);
		int unsigned xl, xh, yl, yh, top, bot;
		logic [7:0] upper, lower, m;
		xl = ax < bx ? ax : bx;
		xh = ax < bx ? bx : ax;
		yl = ay < by ? ay : by;
		yh = ay < by ? by : ay;
		if (xl > WIDTH - 1 || yl > HEIGHT - 1) return;
		if (xh > WIDTH - 1) xh = WIDTH - 1;
		if (yh > HEIGHT - 1) yh = HEIGHT - 1;
		for (int unsigned p = yl / 8; p <= yh / 8; p++) begin
			top = yl > p * 8 ? yl - p * 8 : 0;
			bot = yh < p * 8 + 7 ? yh - p * 8 : 7;
			upper = 8'hFF >> top;
			lower = 8'hFF << (7 - bot);
			m = upper & lower;
			for (int unsigned c = xl; c <= xh; c++) begin
				case (op)
					CMD_CLEAR: pixels[c*PAGES+p] &= ~m;
					CMD_FILL:  pixels[c*PAGES+p] |= m;
					default:   pixels[c*PAGES+p] ^= m;
				endcase
			end
		end
		if (!dirty_set) begin
			dirty_xl = xl; dirty_xh = xh;
			dirty_yl = yl; dirty_yh = yh;
			dirty_set = 1;
		end else begin
			if (xl < dirty_xl) dirty_xl = xl;
			if (xh > dirty_xh) dirty_xh = xh;
			if (yl < dirty_yl) dirty_yl = yl;
			if (yh > dirty_yh) dirty_yh = yh;
		end
	endtask

	// next byte of the panel stream
	function automatic panel_beat_t next_panel_beat();
		panel_beat_t e;
		int unsigned ncols;
		e = '{8'h00, 1'b0, 1'b0, 1'b0};
		if (!sending) begin
			e.idle_flag = 1;
			return e;
		end
		ncols = win_ch - win_cl + 1;
		if (cur_pos == 0) begin
			e.pbyte = PAGE_CMD_BASE + 8'(cur_page & 15);
			e.cmd_flag = 1;
		end else if (cur_pos == 1) begin
			e.pbyte = COL_HI_CMD | 8'((win_cl >> 4) & 15);
			e.cmd_flag = 1;
		end else if (cur_pos == 2) begin
			e.pbyte = 8'(win_cl) & NIBBLE_MASK;
			e.cmd_flag = 1;
		end else begin
			e.pbyte = flip_byte(pixels[(win_cl + cur_pos - 3) * PAGES + cur_page]);
		end
		if (cur_pos >= 2 + ncols) begin
			cur_pos = 0;
			if (cur_page >= win_ph) begin
				e.last_flag = 1;
				sending = 0;
				cur_page = 0;
			end else begin
				cur_page++;
			end
		end else begin
			cur_pos++;
		end
		return e;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		panel_beat_t e;
		if (!arst_n) begin
			clear_shadow();
			panel_q.delete();
			fails = 0;
			fail_count <= 0;
			beats_owed <= 0;
			streaming <= 0;
		end else begin
			// compare each delivered beat with the oldest prediction
			if (out_valid && !out_stall) begin
				if (panel_q.size() == 0) begin
					$error("panel beat with none predicted: byte %0h", panel_byte);
					fails++;
				end else begin
					e = panel_q.pop_front();
					if (panel_byte !== e.pbyte) begin
						$error("panel_byte expected %0h actual %0h", e.pbyte, panel_byte);
						fails++;
					end
					if (is_command !== e.cmd_flag) begin
						$error("is_command expected %0b actual %0b", e.cmd_flag, is_command);
						fails++;
					end
					if (last_of_refresh !== e.last_flag) begin
						$error("last_of_refresh expected %0b actual %0b", e.last_flag,
						       last_of_refresh);
						fails++;
					end
					if (nothing_pending !== e.idle_flag) begin
						$error("nothing_pending expected %0b actual %0b", e.idle_flag,
						       nothing_pending);
						fails++;
					end
				end
			end
			// command beat updates the shadow
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_CLEAR, CMD_FILL, CMD_INVERT: begin
						paint_rect(cmd, corner_a_x, corner_a_y, corner_b_x, corner_b_y);
						if (refresh_after) start_refresh();
					end
					CMD_ARM:  start_refresh();
					CMD_PULL: panel_q.push_back(next_panel_beat());
					default:  ;
				endcase
			end
			fail_count <= fails;
			beats_owed <= panel_q.size();
			streaming <= sending;
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: framebuffer with dirty-rect refresh
// Drives directed and random drawing, refresh and pull beats with varying
// sender gaps and receiver stalls; the checker scores every panel beat.
// ----------------------------------------------------------------------------
module testbench;
	import mfb_pkg::*;

	localparam int STALL_LIMIT = 30000;
	localparam int RANDOM_BEATS = 270;
	localparam int LONG_HOLD = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] cmd = CMD_CLEAR;
	logic [7:0] corner_a_x = '0;
	logic [7:0] corner_a_y = '0;
	logic [7:0] corner_b_x = '0;
	logic [7:0] corner_b_y = '0;
	logic       refresh_after = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] panel_byte;
	logic       is_command;
	logic       last_of_refresh;
	logic       nothing_pending;

	int fail_count;
	int beats_owed;
	bit streaming;
	int gap_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_go = 0;
	int quiet_cycles = 0;
	int beats_sent = 0;
	int base_x = 0;
	int base_y = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mono_framebuffer_dirty_refresh dut (.*);

	framebuffer_checker scoreboard (.*);

	// receiver: random stalls, or one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			hold_go <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("mono_framebuffer_dirty_refresh test failed");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [2:0] c, input logic [7:0] ax, input logic [7:0] ay,
				 input logic [7:0] bx, input logic [7:0] by, input logic rf);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		corner_a_x <= ax;
		corner_a_y <= ay;
		corner_b_x <= bx;
		corner_b_y <= by;
		refresh_after <= rf;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic pull_beat();
		send_beat(CMD_PULL, 8'($urandom_range(255)), 8'($urandom_range(255)),
			  8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// pull until the window is sent, ends with at most one idle pull
	task automatic drain_stream();
		int guard;
		guard = 0;
		do begin
			pull_beat();
			guard++;
		end while (streaming && guard < 1200);
	endtask

	// small rectangle near the current base, corners in random order;
	// bases near the edges push it partly or fully off screen
	task automatic draw_small(input logic rf);
		logic [7:0] x0, y0, x1, y1;
		logic [2:0] op;
		op = 3'($urandom_range(2));
		x0 = 8'(base_x + $urandom_range(7));
		y0 = 8'(base_y + $urandom_range(3));
		x1 = 8'(x0 + $urandom_range(9));
		y1 = 8'(y0 + $urandom_range(5));
		if ($urandom_range(1)) send_beat(op, x1, y1, x0, y0, rf);
		else send_beat(op, x0, y0, x1, y1, rf);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (beats_owed != 0) @(posedge clk);
	endtask

	initial begin
		int n;
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle pull, empty refresh, unused codes
		pull_beat();
		send_beat(CMD_ARM, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_beat(3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_beat(3'd6, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_beat(3'd7, 8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1);
		// fully off screen with refresh: nothing changes, nothing sent
		send_beat(CMD_FILL, 8'd128, 8'd0, 8'd255, 8'd255, 1'b1);
		send_beat(CMD_INVERT, 8'd0, 8'd64, 8'd255, 8'd200, 1'b1);
		pull_beat();
		// single corner pixels, then a corner fill clipped from the extremes
		send_beat(CMD_FILL, 8'd127, 8'd63, 8'd127, 8'd63, 1'b1);
		drain_stream();
		send_beat(CMD_INVERT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		drain_stream();
		send_beat(CMD_FILL, 8'd255, 8'd255, 8'd100, 8'd40, 1'b0);
		send_beat(CMD_CLEAR, 8'd120, 8'd50, 8'd104, 8'd44, 1'b0);
		send_beat(CMD_INVERT, 8'd130, 8'd41, 8'd118, 8'd60, 1'b1);
		// draw and refresh while the window streams
		repeat (20) pull_beat();
		send_beat(CMD_INVERT, 8'd10, 8'd10, 8'd20, 8'd30, 1'b0);
		send_beat(CMD_ARM, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_beat(CMD_CLEAR, 8'd0, 8'd7, 8'd7, 8'd8, 1'b1);
		drain_stream();
		// the region kept during streaming goes out now
		send_beat(CMD_ARM, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
		drain_stream();
		in_valid <= 1'b0;
		wait_drained();

		// long receiver hold-off while pulls keep coming
		send_beat(CMD_FILL, 8'd40, 8'd15, 8'd0, 8'd0, 1'b1);
		hold_go <= 1;
		repeat (40) pull_beat();
		drain_stream();
		in_valid <= 1'b0;
		wait_drained();

		// random: mostly draw/refresh/pull sequences, some noise
		n = beats_sent;
		while (beats_sent - n < RANDOM_BEATS) begin
			phase = ((beats_sent - n) / 60) % 4;
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 57; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 57; end
				default: begin gap_pct = 22; stall_pct = 22; end
			endcase
			base_x = $urandom_range(125);
			base_y = $urandom_range(62);
			if ($urandom_range(4) == 0) begin
				send_beat(3'($urandom_range(7, 3)), 8'($urandom_range(255)),
					  8'($urandom_range(255)), 8'($urandom_range(255)),
					  8'($urandom_range(255)), 1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(3)) draw_small(1'b0);
				if ($urandom_range(1)) draw_small(1'b1);
				else send_beat(CMD_ARM, 8'($urandom_range(255)), 8'd0, 8'd0,
					       8'($urandom_range(255)), 1'b0);
				if ($urandom_range(3) == 0) begin
					repeat ($urandom_range(6)) pull_beat();
					draw_small(1'($urandom_range(1)));
				end
				drain_stream();
			end
		end
		in_valid <= 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("mono_framebuffer_dirty_refresh test passed");
		else
			$display("mono_framebuffer_dirty_refresh test failed");
		$finish;
	end

endmodule
